// File: sv/bpfa_pkg.sv
// Shared constants and types for the bitmap page-frame allocator.
package bpfa_pkg;

  // Process slots follow from the width of the pid field.
  localparam int PID_W      = 3;
  localparam int SLOTS      = 1 << PID_W;

  // Virtual pages per slot; one mask bit per page.
  localparam int VPAGES     = 64;
  localparam int VP_W       = $clog2(VPAGES);

  // Physical frames and the widths that follow from them.
  localparam int FRAMES     = 64;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int FREE_W     = $clog2(FRAMES + 1);
  localparam int PAGE_SHIFT = 12;

  // Page map entry: top bit is the valid flag, the rest is the frame.
  localparam int MAP_W      = FRAME_W + 1;
  localparam int MAP_DEPTH  = SLOTS * VPAGES;
  localparam int MAP_AW     = PID_W + VP_W;

  // Field widths of the stream words.
  localparam int SIZE_W     = 32;
  localparam int MASK_W     = 64;
  localparam int FFREE_W    = 7;
  localparam int OCC_W      = 64;
  localparam int KIND_W     = 2;
  localparam int NEED_W     = SIZE_W + 1;

  localparam int S_TDATA_W  = ((PID_W + SIZE_W + MASK_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((MASK_W + FFREE_W + OCC_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_CLEAN  = 2'd1,
    KIND_ALLOC  = 2'd2,
    KIND_FREE   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [PID_W-1:0]   pid;
    logic [SIZE_W-1:0]  alloc_size;
    logic [MASK_W-1:0]  release_mask;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [MASK_W-1:0]  page_mask;
    logic [FFREE_W-1:0] free_frames;
    logic [OCC_W-1:0]   occupancy;
  } res_t;

  // Access to the page map: one write port and one read port per cycle.
  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] waddr;
    logic [MAP_W-1:0]  wdata;
    logic [MAP_AW-1:0] raddr;
  } map_req_t;

endpackage

// File: sv/bpfa_map_ram.sv
// Page map storage: one entry per slot and virtual page, registered read.
module bpfa_map_ram (
  input  logic                        clk,
  input  bpfa_pkg::map_req_t          req,
  output logic [bpfa_pkg::MAP_W-1:0]  rdata
);

  logic [bpfa_pkg::MAP_W-1:0] mem [bpfa_pkg::MAP_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// File: sv/bpfa_engine.sv
// Request sequencer: walks one slot's row of the page map, one entry per cycle
// unless stalled; keeps frame bitmap, free count, scan pointer and slot flags.
module bpfa_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bpfa_pkg::req_t              in_req,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bpfa_pkg::res_t              res,
  output bpfa_pkg::map_req_t          map_req,
  input  logic [bpfa_pkg::MAP_W-1:0]  map_rdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PREP   = 5'b00010,
    ST_CREATE = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t                            state, state_next;
  logic [bpfa_pkg::SLOTS-1:0]        slot_live, slot_live_next;
  logic [bpfa_pkg::FRAMES-1:0]       frame_bits, frame_bits_next;
  logic [bpfa_pkg::FREE_W-1:0]       free_total, free_total_next;
  logic [bpfa_pkg::FREE_W-1:0]       scan_ptr, scan_ptr_next;

  bpfa_pkg::req_t                    req_r, req_next;
  logic [bpfa_pkg::VP_W-1:0]         vp, vp_next;
  logic [bpfa_pkg::FREE_W-1:0]       need, need_next;
  logic [bpfa_pkg::MASK_W-1:0]       mask, mask_next;
  logic                              ok_r, ok_next;

  logic                              entry_valid;
  logic [bpfa_pkg::FRAME_W-1:0]      entry_frame;
  logic                              last_vp;
  logic                              scan_in_range;
  logic [bpfa_pkg::FRAME_W-1:0]      scan_idx;
  logic [bpfa_pkg::NEED_W-1:0]       need_full;
  logic                              do_release;

  // Decode of the entry read in the previous cycle.
  assign entry_valid   = map_rdata[bpfa_pkg::MAP_W-1];
  assign entry_frame   = map_rdata[bpfa_pkg::FRAME_W-1:0];
  assign last_vp       = (vp == bpfa_pkg::VP_W'(bpfa_pkg::VPAGES - 1));
  assign scan_in_range = (scan_ptr < bpfa_pkg::FREE_W'(bpfa_pkg::FRAMES));
  assign scan_idx      = scan_ptr[bpfa_pkg::FRAME_W-1:0];

  // Pages needed by an alloc, rounded up; only meaningful for a nonzero size.
  assign need_full = ((bpfa_pkg::NEED_W'(req_r.alloc_size) - bpfa_pkg::NEED_W'(1))
                      >> bpfa_pkg::PAGE_SHIFT) + bpfa_pkg::NEED_W'(1);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  assign res.ok          = ok_r;
  assign res.page_mask   = mask;
  assign res.free_frames = bpfa_pkg::FFREE_W'(free_total);
  assign res.occupancy   = bpfa_pkg::OCC_W'(frame_bits);

  // Next-state logic. The write of one entry and the read of the next never
  // hit the same address, so the map needs no forwarding.
  always_comb begin
    state_next      = state;
    slot_live_next  = slot_live;
    frame_bits_next = frame_bits;
    free_total_next = free_total;
    scan_ptr_next   = scan_ptr;
    req_next        = req_r;
    vp_next         = vp;
    need_next       = need;
    mask_next       = mask;
    ok_next         = ok_r;
    do_release      = 1'b0;
    map_req.we      = 1'b0;
    map_req.waddr   = {req_r.pid, vp};
    map_req.wdata   = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_next   = in_req;
          vp_next    = '0;
          mask_next  = '0;
          ok_next    = 1'b0;
          state_next = ST_PREP;
        end
      end

      ST_PREP: begin
        case (req_r.kind)
          bpfa_pkg::KIND_CREATE: begin
            state_next = slot_live[req_r.pid] ? ST_DONE : ST_CREATE;
          end
          bpfa_pkg::KIND_ALLOC: begin
            if (!slot_live[req_r.pid] || (req_r.alloc_size == '0) ||
                (need_full > bpfa_pkg::NEED_W'(free_total))) begin
              state_next = ST_DONE;
            end else begin
              need_next  = need_full[bpfa_pkg::FREE_W-1:0];
              state_next = ST_WALK;
            end
          end
          default: begin
            state_next = slot_live[req_r.pid] ? ST_WALK : ST_DONE;
          end
        endcase
      end

      // Clearing sweep over the new slot's row.
      ST_CREATE: begin
        map_req.we = 1'b1;
        vp_next    = vp + bpfa_pkg::VP_W'(1);
        if (last_vp) begin
          slot_live_next[req_r.pid] = 1'b1;
          ok_next                   = 1'b1;
          state_next                = ST_DONE;
        end
      end

      ST_WALK: begin
        case (req_r.kind)
          bpfa_pkg::KIND_CLEAN, bpfa_pkg::KIND_FREE: begin
            do_release = entry_valid &&
                         ((req_r.kind == bpfa_pkg::KIND_CLEAN) || req_r.release_mask[vp]);
            map_req.we = do_release;
            vp_next    = vp + bpfa_pkg::VP_W'(1);
            if (last_vp) begin
              ok_next    = 1'b1;
              state_next = ST_DONE;
            end
          end
          bpfa_pkg::KIND_ALLOC: begin
            if (entry_valid) begin
              // Page already mapped: move on to the next one.
              vp_next = vp + bpfa_pkg::VP_W'(1);
              if (last_vp) begin
                state_next = ST_DONE;
              end
            end else if (!scan_in_range) begin
              scan_ptr_next = '0;
            end else if (frame_bits[scan_idx]) begin
              // Frame taken: step the scan pointer and read this page again.
              scan_ptr_next = scan_ptr + bpfa_pkg::FREE_W'(1);
            end else begin
              // Map this page to the free frame under the scan pointer.
              frame_bits_next[scan_idx] = 1'b1;
              free_total_next = free_total - bpfa_pkg::FREE_W'(1);
              map_req.we      = 1'b1;
              map_req.wdata   = {1'b1, scan_idx};
              mask_next[vp]   = 1'b1;
              ok_next         = 1'b1;
              scan_ptr_next   = scan_ptr + bpfa_pkg::FREE_W'(1);
              need_next       = need - bpfa_pkg::FREE_W'(1);
              vp_next         = vp + bpfa_pkg::VP_W'(1);
              if (last_vp || (need == bpfa_pkg::FREE_W'(1))) begin
                state_next = ST_DONE;
              end
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Release of the frame held by the current entry.
    if (do_release) begin
      frame_bits_next[entry_frame] = 1'b0;
      free_total_next = free_total + bpfa_pkg::FREE_W'(1);
      if (bpfa_pkg::FREE_W'(entry_frame) < scan_ptr) begin
        scan_ptr_next = bpfa_pkg::FREE_W'(entry_frame);
      end
    end

    // The read address follows the page the walk looks at in the next cycle.
    map_req.raddr = {req_r.pid, vp_next};
  end

  // Control and allocator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_live  <= '0;
      frame_bits <= '0;
      free_total <= bpfa_pkg::FREE_W'(bpfa_pkg::FRAMES);
      scan_ptr   <= '0;
    end else begin
      state      <= state_next;
      slot_live  <= slot_live_next;
      frame_bits <= frame_bits_next;
      free_total <= free_total_next;
      scan_ptr   <= scan_ptr_next;
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    req_r <= req_next;
    vp    <= vp_next;
    need  <= need_next;
    mask  <= mask_next;
    ok_r  <= ok_next;
  end

endmodule

// File: sv/bitmap_page_frame_allocator_unit.sv
// Channel  Dir  Accept on            Contents
// s_*      in   s_tvalid & s_tready  tuser: kind; tdata: pid, alloc_size, release_mask
// m_*      out  m_tvalid & m_tready  tuser: ok; tdata: page_mask, free_frames, occupancy
//
// One request is in work at a time. A request that fails its check (dead or
// live slot as the kind requires, zero or oversized alloc) goes straight to
// its result without a walk. Create, clean and free walk the slot's 64 map
// entries at one entry a cycle through the page map RAM. Alloc looks at the
// slot's pages in order and steps the scan pointer over occupied frames to a
// free one for each unmapped page. Reset is synchronous and needs no clearing
// pass: create sweeps its own row of the map. A result waits in an output
// register, and the next word is taken while it waits; the block stalls only
// when a second result is ready before the first is taken.
module bitmap_page_frame_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] pid, [34:3] alloc_size, [98:35] release_mask, rest zero
  input  logic [bpfa_pkg::S_TDATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  logic [bpfa_pkg::KIND_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [63:0] page_mask, [70:64] free_frames, [134:71] occupancy, rest zero
  output logic [bpfa_pkg::M_TDATA_W-1:0]  m_tdata,
  // [0] ok
  output logic [0:0]                      m_tuser
);

  localparam int SIZE_LO = bpfa_pkg::PID_W;
  localparam int MASK_LO = SIZE_LO + bpfa_pkg::SIZE_W;
  localparam int OUT_USED = bpfa_pkg::MASK_W + bpfa_pkg::FFREE_W + bpfa_pkg::OCC_W;

  bpfa_pkg::req_t                  in_req;
  bpfa_pkg::res_t                  res;
  bpfa_pkg::res_t                  out_res;
  bpfa_pkg::map_req_t              map_req;
  logic [bpfa_pkg::MAP_W-1:0]      map_rdata;
  logic                            res_valid;
  logic                            res_ready;

  // Unpack the input word.
  assign in_req.kind         = bpfa_pkg::kind_t'(s_tuser);
  assign in_req.pid          = s_tdata[bpfa_pkg::PID_W-1:0];
  assign in_req.alloc_size   = s_tdata[SIZE_LO +: bpfa_pkg::SIZE_W];
  assign in_req.release_mask = s_tdata[MASK_LO +: bpfa_pkg::MASK_W];

  bpfa_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .map_req   (map_req),
    .map_rdata (map_rdata)
  );

  bpfa_map_ram u_map (
    .clk   (clk),
    .req   (map_req),
    .rdata (map_rdata)
  );

  // Output register: loads when empty or when its word is being taken.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  // Pack the output word.
  assign m_tuser = out_res.ok;
  assign m_tdata = {(bpfa_pkg::M_TDATA_W - OUT_USED)'(0), out_res.occupancy,
                    out_res.free_frames, out_res.page_mask};

endmodule

// File: sv/bpfa_checker.sv
// Port-level checks for the allocator.
module bpfa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [bpfa_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [0:0]                      m_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Only one request is in work: the input closes right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a request is in work");

  // The free count in a valid result word matches the occupancy bitmap.
  a_free_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tdata[134:71]) + int'(m_tdata[70:64]) == 64))
    else $error("free count disagrees with occupancy");

  // A failed request never reports newly mapped pages.
  a_fail_no_pages: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[63:0] == 64'd0))
    else $error("failed request reported a page mask");

endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker u_bpfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
